// ----- hw/rtl/kwslm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, protocol bytes and sizes for the serial link master.
// Used by kwslm_ctl, kwslm_dp and kw_serial_link_master; depends on nothing.
package kwslm_pkg;

    localparam int MAX_PAYLOAD = 8;
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int IDX_W       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int POS_W       = $clog2(MAX_PAYLOAD + 5);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_W       = 16;

    localparam int POS_START   = 0;
    localparam int POS_CMD     = 1;
    localparam int POS_ADDR_HI = 2;
    localparam int POS_ADDR_LO = 3;
    localparam int POS_LEN     = 4;

    localparam logic [7:0] SYNC_BYTE  = 8'h05;
    localparam logic [7:0] RESET_BYTE = 8'h04;
    localparam logic [7:0] START_BYTE = 8'h01;
    localparam logic [7:0] CMD_READ   = 8'hF7;
    localparam logic [7:0] CMD_WRITE  = 8'hF4;

    localparam logic [CFG_W-1:0] INIT_RETRY_RST     = 16'd1000;
    localparam logic [CFG_W-1:0] FAST_WINDOW_RST    = 16'd10;
    localparam logic [CFG_W-1:0] IDLE_TIMEOUT_RST   = 16'd5000;
    localparam logic [CFG_W-1:0] ANSWER_TIMEOUT_RST = 16'd1000;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_BYTE   = 2'd1,
        ACT_HEADER = 2'd2,
        ACT_DATA   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_TX     = 2'd0,
        KIND_ANSWER = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INIT_RETRY     = 2'd0,
        CFG_FAST_WINDOW    = 2'd1,
        CFG_IDLE_TIMEOUT   = 2'd2,
        CFG_ANSWER_TIMEOUT = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        EM_FRAME  = 2'd0,
        EM_ANSWER = 2'd1,
        EM_RETRY  = 2'd2,
        EM_ERROR  = 2'd3
    } emit_t;

    typedef struct packed {
        action_t     action;
        logic [7:0]  rx_byte;
        logic [15:0] req_address;
        logic [3:0]  req_length;
        logic        req_write;
        logic [7:0]  req_data;
    } in_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        logic       last;
    } out_t;

    typedef struct packed {
        logic  capture;
        logic  load_header;
        logic  store_payload;
        logic  store_answer;
        logic  clear_elapsed;
        logic  retire;
        logic  start_emit;
        emit_t mode;
        logic  with_sync;
        logic  advance;
    } cmd_t;

    typedef struct packed {
        action_t action;
        logic    is_sync;
        logic    req_ready;
        logic    payload_ok;
        logic    answer_room;
        logic    answer_done;
        logic    fast_ok;
        logic    idle_expired;
        logic    answer_expired;
        logic    retry_expired;
        logic    emit_last;
    } stat_t;

endpackage

// ----- hw/rtl/kw_serial_link_master.sv -----
`timescale 1ns / 1ps
// Top level of the serial link master: controller plus datapath.
// Depends on kwslm_pkg, kwslm_ctl and kwslm_dp.
//
// Input channel (in_valid/in_ready/in_data) carries one event per word: a
// millisecond tick, a received byte, a request header or one write byte.
// Output channel (out_valid/out_ready/out_data) returns the words each event
// causes: bytes to transmit, answer bytes for the host, or a timeout error;
// last marks the final word of one event. Events that cause nothing return
// no word.
// Timing: an event is taken in one cycle and evaluated in the next; its
// words then follow one per cycle from the sequencer while out_ready is
// high, with up to 13 result words for one event.
// One event is handled at a time; in_ready is low from acceptance until the
// last word has been taken.
// A stalled receiver holds the current word on out_data and stops the
// sequencer; nothing is dropped.
// Reset puts the link in init with the request slot empty and the timing
// registers at their defaults. The config port writes one register per
// cycle with cfg_we and takes effect at once; write only while idle.
module kw_serial_link_master (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  kwslm_pkg::in_t                      in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output kwslm_pkg::out_t                     out_data,
    input  logic                                cfg_we,
    input  logic [kwslm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kwslm_pkg::CFG_W-1:0]         cfg_wdata
);

    kwslm_pkg::cmd_t  cmd;
    kwslm_pkg::stat_t stat;

    kwslm_ctl u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    kwslm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (out_data)
    );

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while words are pending");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second word taken before evaluation");

    a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.kind == kwslm_pkg::KIND_ERROR) |->
        (out_data.last && out_data.value == 8'd0))
        else $error("timeout error word malformed");

    a_emit_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready && !out_valid))
        else $error("words started without an evaluated event");

endmodule

// ----- hw/rtl/kwslm_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the serial link master: config, timer, request slot, stores, word generator.
// Depends on kwslm_pkg; driven by commands from kwslm_ctl.
module kwslm_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  kwslm_pkg::in_t                       in_data,
    input  logic                                 cfg_we,
    input  logic [kwslm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kwslm_pkg::CFG_W-1:0]          cfg_wdata,
    input  kwslm_pkg::cmd_t                      cmd,
    output kwslm_pkg::stat_t                     stat,
    output kwslm_pkg::out_t                      out_data
);

    localparam int CNT_W = kwslm_pkg::CNT_W;
    localparam int IDX_W = kwslm_pkg::IDX_W;
    localparam int POS_W = kwslm_pkg::POS_W;

    logic [15:0]         retry_reg;
    logic [15:0]         fast_reg;
    logic [15:0]         idle_to_reg;
    logic [15:0]         ans_to_reg;
    logic [15:0]         elapsed_reg;
    kwslm_pkg::in_t      item_reg;
    logic                pending_reg;
    logic [15:0]         addr_reg;
    logic [CNT_W-1:0]    len_reg;
    logic                write_reg;
    logic [CNT_W-1:0]    fill_reg;
    logic [CNT_W-1:0]    ans_cnt_reg;
    logic [CNT_W-1:0]    exp_reg;
    logic [7:0]          payload_reg [kwslm_pkg::MAX_PAYLOAD];
    logic [7:0]          answer_reg [kwslm_pkg::MAX_PAYLOAD];
    kwslm_pkg::emit_t    mode_reg;
    logic [POS_W-1:0]    pos_reg;

    logic [CNT_W-1:0]    hdr_len;
    logic [POS_W-1:0]    frame_end;
    logic [POS_W-1:0]    pay_pos;
    logic [IDX_W-1:0]    pay_idx;
    logic [IDX_W-1:0]    ans_idx;
    logic [CNT_W:0]      ans_cnt_inc;
    logic [7:0]          frame_value;
    logic                emit_last;

    always_comb
    begin
        if (item_reg.req_length == 4'd0)
        begin
            hdr_len = CNT_W'(1);
        end
        else if (int'(item_reg.req_length) > kwslm_pkg::MAX_PAYLOAD)
        begin
            hdr_len = CNT_W'(kwslm_pkg::MAX_PAYLOAD);
        end
        else
        begin
            hdr_len = CNT_W'(item_reg.req_length);
        end
    end

    assign ans_cnt_inc = {1'b0, ans_cnt_reg} + (CNT_W + 1)'(1);

    always_comb
    begin
        stat.action         = item_reg.action;
        stat.is_sync        = (item_reg.rx_byte == kwslm_pkg::SYNC_BYTE);
        stat.req_ready      = pending_reg && (!write_reg || (fill_reg >= len_reg));
        stat.payload_ok     = pending_reg && write_reg && (fill_reg < len_reg);
        stat.answer_room    = (ans_cnt_reg < exp_reg);
        stat.answer_done    = stat.answer_room ? (ans_cnt_inc >= {1'b0, exp_reg})
                                               : (ans_cnt_reg >= exp_reg);
        stat.fast_ok        = (elapsed_reg < fast_reg);
        stat.idle_expired   = (elapsed_reg > idle_to_reg);
        stat.answer_expired = (elapsed_reg > ans_to_reg);
        stat.retry_expired  = (elapsed_reg > retry_reg);
        stat.emit_last      = emit_last;
    end

    assign frame_end = write_reg ? (POS_W'(kwslm_pkg::POS_LEN) + POS_W'(len_reg))
                                 : POS_W'(kwslm_pkg::POS_LEN);
    assign pay_pos   = pos_reg - POS_W'(kwslm_pkg::POS_LEN + 1);
    assign pay_idx   = pay_pos[IDX_W-1:0];
    assign ans_idx   = pos_reg[IDX_W-1:0];

    always_comb
    begin
        case (pos_reg)
            POS_W'(kwslm_pkg::POS_START):   frame_value = kwslm_pkg::START_BYTE;
            POS_W'(kwslm_pkg::POS_CMD):     frame_value = write_reg ? kwslm_pkg::CMD_WRITE
                                                                    : kwslm_pkg::CMD_READ;
            POS_W'(kwslm_pkg::POS_ADDR_HI): frame_value = addr_reg[15:8];
            POS_W'(kwslm_pkg::POS_ADDR_LO): frame_value = addr_reg[7:0];
            POS_W'(kwslm_pkg::POS_LEN):     frame_value = 8'(len_reg);
            default:                        frame_value = payload_reg[pay_idx];
        endcase
    end

    always_comb
    begin
        unique case (mode_reg)
            kwslm_pkg::EM_FRAME:
            begin
                out_data.kind  = kwslm_pkg::KIND_TX;
                out_data.value = frame_value;
                emit_last      = (pos_reg == frame_end);
            end
            kwslm_pkg::EM_ANSWER:
            begin
                out_data.kind  = kwslm_pkg::KIND_ANSWER;
                out_data.value = write_reg ? payload_reg[ans_idx] : answer_reg[ans_idx];
                emit_last      = (pos_reg == (POS_W'(len_reg) - POS_W'(1)));
            end
            kwslm_pkg::EM_RETRY:
            begin
                out_data.kind  = kwslm_pkg::KIND_TX;
                out_data.value = kwslm_pkg::RESET_BYTE;
                emit_last      = 1'b1;
            end
            default:
            begin
                out_data.kind  = kwslm_pkg::KIND_ERROR;
                out_data.value = 8'd0;
                emit_last      = 1'b1;
            end
        endcase
        out_data.last = emit_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_reg   <= kwslm_pkg::INIT_RETRY_RST;
            fast_reg    <= kwslm_pkg::FAST_WINDOW_RST;
            idle_to_reg <= kwslm_pkg::IDLE_TIMEOUT_RST;
            ans_to_reg  <= kwslm_pkg::ANSWER_TIMEOUT_RST;
            elapsed_reg <= '0;
            pending_reg <= 1'b0;
            addr_reg    <= '0;
            len_reg     <= '0;
            write_reg   <= 1'b0;
            fill_reg    <= '0;
            ans_cnt_reg <= '0;
            exp_reg     <= '0;
            mode_reg    <= kwslm_pkg::EM_FRAME;
            pos_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    kwslm_pkg::CFG_INIT_RETRY:     retry_reg   <= cfg_wdata;
                    kwslm_pkg::CFG_FAST_WINDOW:    fast_reg    <= cfg_wdata;
                    kwslm_pkg::CFG_IDLE_TIMEOUT:   idle_to_reg <= cfg_wdata;
                    kwslm_pkg::CFG_ANSWER_TIMEOUT: ans_to_reg  <= cfg_wdata;
                    default:                       retry_reg   <= retry_reg;
                endcase
            end

            if (cmd.capture && (in_data.action == kwslm_pkg::ACT_TICK) &&
                (elapsed_reg != 16'hFFFF))
            begin
                elapsed_reg <= elapsed_reg + 16'd1;
            end
            else if (cmd.clear_elapsed)
            begin
                elapsed_reg <= '0;
            end

            if (cmd.load_header)
            begin
                pending_reg <= 1'b1;
                addr_reg    <= item_reg.req_address;
                len_reg     <= hdr_len;
                write_reg   <= item_reg.req_write;
                fill_reg    <= '0;
            end
            else if (cmd.store_payload)
            begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
            else if (cmd.retire)
            begin
                pending_reg <= 1'b0;
                fill_reg    <= '0;
            end

            if (cmd.store_answer)
            begin
                ans_cnt_reg <= ans_cnt_inc[CNT_W-1:0];
            end
            else if (cmd.start_emit &&
                     (cmd.mode == kwslm_pkg::EM_FRAME || cmd.mode == kwslm_pkg::EM_ERROR))
            begin
                ans_cnt_reg <= '0;
            end

            if (cmd.start_emit && (cmd.mode == kwslm_pkg::EM_FRAME))
            begin
                exp_reg <= write_reg ? CNT_W'(1) : len_reg;
            end

            if (cmd.start_emit)
            begin
                mode_reg <= cmd.mode;
                pos_reg  <= ((cmd.mode == kwslm_pkg::EM_FRAME) && !cmd.with_sync)
                            ? POS_W'(kwslm_pkg::POS_CMD) : POS_W'(kwslm_pkg::POS_START);
            end
            else if (cmd.advance)
            begin
                pos_reg <= pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_data;
        end
        if (cmd.store_payload)
        begin
            payload_reg[fill_reg[IDX_W-1:0]] <= item_reg.req_data;
        end
        if (cmd.store_answer)
        begin
            answer_reg[ans_cnt_reg[IDX_W-1:0]] <= item_reg.rx_byte;
        end
    end

endmodule

// ----- hw/rtl/kwslm_ctl.sv -----
`timescale 1ns / 1ps
// Controller of the serial link master: link phase and word sequencing.
// Depends on kwslm_pkg; commands kwslm_dp and reads its status.
module kwslm_ctl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  kwslm_pkg::stat_t   stat,
    output kwslm_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        PH_INIT = 2'd0,
        PH_IDLE = 2'd1,
        PH_RECV = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_READY = 2'd0,
        ST_EVAL  = 2'd1,
        ST_EMIT  = 2'd2
    } state_t;

    phase_t phase_reg;
    phase_t phase_next;
    state_t state_reg;
    state_t state_next;

    assign in_ready  = (state_reg == ST_READY);
    assign out_valid = (state_reg == ST_EMIT);

    always_comb
    begin
        cmd        = '0;
        phase_next = phase_reg;
        state_next = state_reg;
        unique case (state_reg)
            ST_READY:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_READY;
                unique case (stat.action)
                    kwslm_pkg::ACT_TICK:
                    begin
                        unique case (phase_reg)
                            PH_IDLE:
                            begin
                                if (stat.req_ready && stat.fast_ok)
                                begin
                                    cmd.start_emit    = 1'b1;
                                    cmd.mode          = kwslm_pkg::EM_FRAME;
                                    cmd.clear_elapsed = 1'b1;
                                    phase_next        = PH_RECV;
                                    state_next        = ST_EMIT;
                                end
                                else if (stat.idle_expired)
                                begin
                                    phase_next = PH_INIT;
                                end
                            end
                            PH_RECV:
                            begin
                                if (stat.answer_expired)
                                begin
                                    cmd.start_emit = 1'b1;
                                    cmd.mode       = kwslm_pkg::EM_ERROR;
                                    cmd.retire     = 1'b1;
                                    phase_next     = PH_INIT;
                                    state_next     = ST_EMIT;
                                end
                            end
                            default:
                            begin
                                phase_next = PH_INIT;
                                if (stat.retry_expired)
                                begin
                                    cmd.start_emit    = 1'b1;
                                    cmd.mode          = kwslm_pkg::EM_RETRY;
                                    cmd.clear_elapsed = 1'b1;
                                    state_next        = ST_EMIT;
                                end
                            end
                        endcase
                    end
                    kwslm_pkg::ACT_BYTE:
                    begin
                        if (phase_reg == PH_RECV)
                        begin
                            cmd.store_answer = stat.answer_room;
                            if (stat.answer_done)
                            begin
                                cmd.start_emit    = 1'b1;
                                cmd.mode          = kwslm_pkg::EM_ANSWER;
                                cmd.clear_elapsed = 1'b1;
                                cmd.retire        = 1'b1;
                                phase_next        = PH_IDLE;
                                state_next        = ST_EMIT;
                            end
                        end
                        else
                        begin
                            if (phase_reg != PH_IDLE)
                            begin
                                phase_next = PH_INIT;
                            end
                            if (stat.is_sync)
                            begin
                                cmd.clear_elapsed = 1'b1;
                                phase_next        = PH_IDLE;
                                if (stat.req_ready)
                                begin
                                    cmd.start_emit = 1'b1;
                                    cmd.mode       = kwslm_pkg::EM_FRAME;
                                    cmd.with_sync  = 1'b1;
                                    phase_next     = PH_RECV;
                                    state_next     = ST_EMIT;
                                end
                            end
                        end
                    end
                    kwslm_pkg::ACT_HEADER:
                    begin
                        cmd.load_header = (phase_reg != PH_RECV);
                    end
                    default:
                    begin
                        cmd.store_payload = (phase_reg != PH_RECV) && stat.payload_ok;
                    end
                endcase
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    cmd.advance = 1'b1;
                    if (stat.emit_last)
                    begin
                        state_next = ST_READY;
                    end
                end
            end
            default:
            begin
                state_next = ST_READY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_INIT;
            state_reg <= ST_READY;
        end
        else
        begin
            phase_reg <= phase_next;
            state_reg <= state_next;
        end
    end

endmodule

// ----- tb/tb_kw_serial_link_master.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for kw_serial_link_master: directed rows, then random link traffic,
// predicted by an in-bench model of the link and checked word by word on the result channel.
// Depends on kwslm_pkg and the kw_serial_link_master RTL only.
module tb;
    import kwslm_pkg::*;

    localparam int LIMIT = 600000;
    localparam logic [3:0] PAYLOAD_CAP = 4'(MAX_PAYLOAD);

    typedef enum logic [1:0] {
        LINK_INIT = 2'd0,
        LINK_IDLE = 2'd1,
        LINK_RECV = 2'd2
    } link_phase_t;

    typedef struct {
        bit               setup;
        logic [3:0][15:0] regs;
        in_t              ev;
        bit               typed;
        int               n;
        out_t             w;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_wdata;

    logic [15:0] retry_ms;
    logic [15:0] window_ms;
    logic [15:0] idle_ms;
    logic [15:0] answer_ms;

    link_phase_t link_phase;
    logic [15:0] elapsed;
    logic        req_pending;
    logic [15:0] req_addr;
    logic [3:0]  req_len;
    logic        req_is_write;
    logic [7:0]  req_payload [MAX_PAYLOAD];
    logic [3:0]  req_fill;
    logic [7:0]  ans_store [MAX_PAYLOAD];
    logic [3:0]  ans_count;
    logic [3:0]  ans_expected;

    out_t      event_words [$];
    out_t      owed_words [$];
    out_t      owed_head;
    plan_row_t plan [$];

    int  mismatches = 0;
    int  events_sent = 0;
    int  stall_left = 0;
    int  cycle_count = 0;
    bit  gaps_on = 1'b1;
    bit  stalls_on = 1'b1;

    kw_serial_link_master dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    function automatic out_t word(input kind_t k, input logic [7:0] v);
        out_t w;
        w.kind  = k;
        w.value = v;
        w.last  = 1'b0;
        return w;
    endfunction

    function automatic bit request_ready();
        return req_pending && (!req_is_write || req_fill >= req_len);
    endfunction

    task automatic transmit_frame(input bit with_start);
        int i;
        if (with_start)
            event_words.push_back(word(KIND_TX, START_BYTE));
        event_words.push_back(word(KIND_TX, req_is_write ? CMD_WRITE : CMD_READ));
        event_words.push_back(word(KIND_TX, req_addr[15:8]));
        event_words.push_back(word(KIND_TX, req_addr[7:0]));
        event_words.push_back(word(KIND_TX, {4'd0, req_len}));
        if (req_is_write)
        begin
            for (i = 0; i < int'(req_len); i++)
                event_words.push_back(word(KIND_TX, req_payload[i]));
            ans_expected = 4'd1;
        end
        else
        begin
            ans_expected = req_len;
        end
        ans_count  = 4'd0;
        link_phase = LINK_RECV;
        elapsed    = 16'd0;
    endtask

    task automatic run_link_event(input in_t ev);
        int i;
        logic [3:0] n;
        out_t tail;
        event_words.delete();
        case (ev.action)
            ACT_TICK:
            begin
                if (elapsed != 16'hFFFF)
                    elapsed = elapsed + 16'd1;
                if (link_phase == LINK_IDLE)
                begin
                    if (request_ready() && elapsed < window_ms)
                        transmit_frame(1'b0);
                    else if (elapsed > idle_ms)
                        link_phase = LINK_INIT;
                end
                else if (link_phase == LINK_RECV)
                begin
                    if (elapsed > answer_ms)
                    begin
                        event_words.push_back(word(KIND_ERROR, 8'h00));
                        req_pending = 1'b0;
                        req_fill    = 4'd0;
                        ans_count   = 4'd0;
                        link_phase  = LINK_INIT;
                    end
                end
                else if (elapsed > retry_ms)
                begin
                    elapsed = 16'd0;
                    event_words.push_back(word(KIND_TX, RESET_BYTE));
                end
            end
            ACT_BYTE:
            begin
                if (link_phase == LINK_RECV)
                begin
                    if (ans_count < ans_expected)
                    begin
                        ans_store[ans_count] = ev.rx_byte;
                        ans_count = ans_count + 4'd1;
                    end
                    if (ans_count >= ans_expected)
                    begin
                        link_phase = LINK_IDLE;
                        elapsed    = 16'd0;
                        if (req_is_write)
                            for (i = 0; i < int'(req_len); i++)
                                event_words.push_back(word(KIND_ANSWER, req_payload[i]));
                        else
                            for (i = 0; i < int'(ans_count); i++)
                                event_words.push_back(word(KIND_ANSWER, ans_store[i]));
                        req_pending = 1'b0;
                        req_fill    = 4'd0;
                    end
                end
                else if (ev.rx_byte == SYNC_BYTE)
                begin
                    link_phase = LINK_IDLE;
                    elapsed    = 16'd0;
                    if (request_ready())
                        transmit_frame(1'b1);
                end
            end
            ACT_HEADER:
            begin
                if (link_phase != LINK_RECV)
                begin
                    n = ev.req_length;
                    if (n == 4'd0)
                        n = 4'd1;
                    if (n > PAYLOAD_CAP)
                        n = PAYLOAD_CAP;
                    req_addr     = ev.req_address;
                    req_len      = n;
                    req_is_write = ev.req_write;
                    req_fill     = 4'd0;
                    req_pending  = 1'b1;
                end
            end
            default:
            begin
                if (link_phase != LINK_RECV && req_pending && req_is_write &&
                    req_fill < req_len)
                begin
                    req_payload[req_fill] = ev.req_data;
                    req_fill = req_fill + 4'd1;
                end
            end
        endcase
        if (event_words.size() > 0)
        begin
            tail = event_words.pop_back();
            tail.last = 1'b1;
            event_words.push_back(tail);
        end
    endtask

    function automatic in_t make_event(input action_t a, input logic [7:0] rx,
                                       input logic [15:0] addr, input logic [3:0] len,
                                       input logic wr, input logic [7:0] d);
        in_t ev;
        ev.action      = a;
        ev.rx_byte     = rx;
        ev.req_address = addr;
        ev.req_length  = len;
        ev.req_write   = wr;
        ev.req_data    = d;
        return ev;
    endfunction

    function automatic in_t rand_event(input action_t a);
        return make_event(a, 8'($urandom), 16'($urandom), 4'($urandom_range(0, 15)),
                          1'($urandom_range(0, 1)), 8'($urandom));
    endfunction

    task automatic note_mismatch(input string what, input out_t want, input out_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s: expected kind=%0d value=%02h last=%0b, %s",
                     $time, what, want.kind, want.value, want.last,
                     $sformatf("got kind=%0d value=%02h last=%0b",
                               got.kind, got.value, got.last));
    endtask

    task automatic offer_event(input in_t ev, input bit typed, input int n, input out_t w);
        int gap;
        int i;
        gap = (gaps_on && $urandom_range(0, 4) == 0) ? int'($urandom_range(1, 9)) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        run_link_event(ev);
        if (typed)
        begin
            if (n > 0)
                owed_words.push_back(w);
        end
        else
        begin
            for (i = 0; i < event_words.size(); i++)
                owed_words.push_back(event_words[i]);
        end
        events_sent++;
    endtask

    task automatic send_event(input in_t ev);
        offer_event(ev, 1'b0, 0, '0);
    endtask

    task automatic send_rx(input logic [7:0] b);
        in_t ev;
        ev = rand_event(ACT_BYTE);
        ev.rx_byte = b;
        send_event(ev);
    endtask

    task automatic drain_words();
        while (owed_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        case (idx)
            CFG_INIT_RETRY:   retry_ms  = v;
            CFG_FAST_WINDOW:  window_ms = v;
            CFG_IDLE_TIMEOUT: idle_ms   = v;
            default:          answer_ms = v;
        endcase
    endtask

    task automatic load_registers(input logic [15:0] retry, input logic [15:0] window,
                                  input logic [15:0] idle, input logic [15:0] answer);
        in_valid <= 1'b0;
        drain_words();
        repeat (20) @(posedge clk);
        write_register(CFG_INIT_RETRY, retry);
        write_register(CFG_FAST_WINDOW, window);
        write_register(CFG_IDLE_TIMEOUT, idle);
        write_register(CFG_ANSWER_TIMEOUT, answer);
        cfg_we <= 1'b0;
    endtask

    task automatic plan_row(input in_t ev, input bit typed, input int n,
                            input kind_t k, input logic [7:0] v);
        plan_row_t row;
        row.setup = 1'b0;
        row.regs  = '0;
        row.ev    = ev;
        row.typed = typed;
        row.n     = n;
        row.w     = word(k, v);
        row.w.last = 1'b1;
        plan.push_back(row);
    endtask

    task automatic build_plan();
        plan_row_t row;
        plan_row(make_event(ACT_TICK, 8'h00, 16'h0000, 4'd0, 1'b0, 8'h00), 1, 0, KIND_TX, 8'h00);
        plan_row(make_event(ACT_BYTE, 8'h42, 16'h0000, 4'd0, 1'b0, 8'h00), 1, 0, KIND_TX, 8'h00);
        plan_row(make_event(ACT_BYTE, SYNC_BYTE, 16'h0000, 4'd0, 1'b0, 8'h00), 1, 0, KIND_TX, 8'h00);
        plan_row(make_event(ACT_HEADER, 8'h00, 16'hFFFF, 4'd2, 1'b1, 8'h00), 1, 0, KIND_TX, 8'h00);
        plan_row(make_event(ACT_DATA, 8'h00, 16'h0000, 4'd0, 1'b0, 8'h00), 0, 0, KIND_TX, 8'h00);
        plan_row(make_event(ACT_DATA, 8'h00, 16'h0000, 4'd0, 1'b0, 8'hFF), 0, 0, KIND_TX, 8'h00);
        plan_row(make_event(ACT_DATA, 8'h00, 16'h0000, 4'd0, 1'b0, 8'h33), 0, 0, KIND_TX, 8'h00);
        plan_row(make_event(ACT_TICK, 8'h00, 16'h0000, 4'd0, 1'b0, 8'h00), 0, 0, KIND_TX, 8'h00);
        plan_row(make_event(ACT_BYTE, 8'h5A, 16'h0000, 4'd0, 1'b0, 8'h00), 0, 0, KIND_TX, 8'h00);
        plan_row(make_event(ACT_HEADER, 8'h00, 16'h0000, 4'd0, 1'b0, 8'h00), 0, 0, KIND_TX, 8'h00);
        plan_row(make_event(ACT_DATA, 8'h00, 16'h0000, 4'd0, 1'b0, 8'h11), 0, 0, KIND_TX, 8'h00);
        plan_row(make_event(ACT_BYTE, SYNC_BYTE, 16'h0000, 4'd0, 1'b0, 8'h00), 0, 0, KIND_TX, 8'h00);
        plan_row(make_event(ACT_HEADER, 8'h00, 16'h1234, 4'd3, 1'b1, 8'h00), 0, 0, KIND_TX, 8'h00);
        plan_row(make_event(ACT_BYTE, 8'hC3, 16'h0000, 4'd0, 1'b0, 8'h00), 0, 0, KIND_TX, 8'h00);
        row.setup = 1'b1;
        row.regs  = {16'd1, 16'hFFFF, 16'd0, 16'd1};
        row.ev    = '0;
        row.typed = 1'b0;
        row.n     = 0;
        row.w     = '0;
        plan.push_back(row);
        plan_row(make_event(ACT_HEADER, 8'h00, 16'h8001, 4'd15, 1'b0, 8'h00), 0, 0, KIND_TX, 8'h00);
        plan_row(make_event(ACT_TICK, 8'h00, 16'h0000, 4'd0, 1'b0, 8'h00), 0, 0, KIND_TX, 8'h00);
        plan_row(make_event(ACT_BYTE, SYNC_BYTE, 16'h0000, 4'd0, 1'b0, 8'h00), 0, 0, KIND_TX, 8'h00);
        plan_row(make_event(ACT_TICK, 8'h00, 16'h0000, 4'd0, 1'b0, 8'h00), 0, 0, KIND_TX, 8'h00);
        plan_row(make_event(ACT_TICK, 8'h00, 16'h0000, 4'd0, 1'b0, 8'h00), 1, 1, KIND_ERROR, 8'h00);
        plan_row(make_event(ACT_TICK, 8'h00, 16'h0000, 4'd0, 1'b0, 8'h00), 1, 1, KIND_TX, RESET_BYTE);
        plan_row(make_event(ACT_TICK, 8'h00, 16'h0000, 4'd0, 1'b0, 8'h00), 1, 0, KIND_TX, 8'h00);
        plan_row(make_event(ACT_TICK, 8'h00, 16'h0000, 4'd0, 1'b0, 8'h00), 1, 1, KIND_TX, RESET_BYTE);
        plan_row(make_event(ACT_BYTE, SYNC_BYTE, 16'h0000, 4'd0, 1'b0, 8'h00), 1, 0, KIND_TX, 8'h00);
    endtask

    task automatic play_exchange();
        in_t ev;
        int pick;
        int eff;
        int nbytes;
        int k;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            ev = rand_event(ACT_HEADER);
            if ($urandom_range(0, 9) == 0)
                ev.req_length = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
            else
                ev.req_length = 4'($urandom_range(1, MAX_PAYLOAD));
            send_event(ev);
            eff = (ev.req_length == 4'd0) ? 1 :
                  (ev.req_length > PAYLOAD_CAP) ? MAX_PAYLOAD : int'(ev.req_length);
            if (ev.req_write)
            begin
                nbytes = eff;
                k = $urandom_range(0, 9);
                if (k == 0)
                    nbytes = eff - 1;
                else if (k == 1)
                    nbytes = eff + 1;
                repeat (nbytes) send_event(rand_event(ACT_DATA));
            end
            if ($urandom_range(0, 4) < 3)
            begin
                if ($urandom_range(0, 5) == 0)
                    send_rx(8'($urandom));
                send_rx(SYNC_BYTE);
            end
            else
            begin
                send_event(rand_event(ACT_TICK));
            end
            if (link_phase == LINK_RECV)
            begin
                nbytes = int'(ans_expected);
                k = $urandom_range(0, 9);
                if (k == 0)
                    nbytes = $urandom_range(0, int'(ans_expected) - 1);
                else if (k == 1)
                    nbytes = nbytes + int'($urandom_range(1, 2));
                repeat (nbytes) send_rx(8'($urandom));
                if (k == 0)
                    repeat ($urandom_range(1, 12)) send_event(rand_event(ACT_TICK));
            end
            repeat ($urandom_range(0, 3)) send_event(rand_event(ACT_TICK));
        end
        else if (pick < 82)
        begin
            repeat ($urandom_range(1, 8)) send_event(rand_event(ACT_TICK));
        end
        else if (pick < 94)
        begin
            send_rx(($urandom_range(0, 3) == 0) ? SYNC_BYTE : 8'($urandom));
        end
        else
        begin
            send_event(rand_event((pick < 97) ? ACT_DATA : ACT_HEADER));
        end
        if ($urandom_range(0, 29) == 0)
        begin
            in_valid <= 1'b0;
            drain_words();
            @(posedge clk);
        end
    endtask

    task automatic run_random(input int count);
        int start;
        start = events_sent;
        while (events_sent - start < count)
            play_exchange();
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (owed_words.size() == 0)
                begin
                    note_mismatch("word with nothing owed", '0, out_data);
                end
                else
                begin
                    owed_head = owed_words.pop_front();
                    if (out_data.kind !== owed_head.kind || out_data.value !== owed_head.value ||
                        out_data.last !== owed_head.last)
                        note_mismatch("word differs", owed_head, out_data);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (stalls_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 9) - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int i;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        retry_ms  = INIT_RETRY_RST;
        window_ms = FAST_WINDOW_RST;
        idle_ms   = IDLE_TIMEOUT_RST;
        answer_ms = ANSWER_TIMEOUT_RST;
        link_phase   = LINK_INIT;
        elapsed      = 16'd0;
        req_pending  = 1'b0;
        req_addr     = 16'd0;
        req_len      = 4'd0;
        req_is_write = 1'b0;
        req_fill     = 4'd0;
        ans_count    = 4'd0;
        ans_expected = 4'd0;
        for (i = 0; i < MAX_PAYLOAD; i++)
        begin
            req_payload[i] = 8'h00;
            ans_store[i]   = 8'h00;
        end
        build_plan();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < plan.size(); i++)
        begin
            if (plan[i].setup)
                load_registers(plan[i].regs[3], plan[i].regs[2], plan[i].regs[1],
                               plan[i].regs[0]);
            else
                offer_event(plan[i].ev, plan[i].typed, plan[i].n, plan[i].w);
        end

        load_registers(16'd3, 16'd4, 16'd20, 16'd6);
        run_random(120);
        load_registers(16'hFFFF, 16'hFFFF, 16'd1, 16'hFFFF);
        run_random(100);
        load_registers(16'($urandom_range(1, 8)), 16'($urandom_range(0, 8)),
                       16'($urandom_range(1, 12)), 16'($urandom_range(1, 10)));
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        run_random(60);
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        run_random(60);
        load_registers(16'($urandom_range(1, 8)), 16'($urandom_range(0, 8)),
                       16'($urandom_range(1, 12)), 16'($urandom_range(1, 10)));
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        run_random(140);

        in_valid <= 1'b0;
        drain_words();
        repeat (30) @(posedge clk);
        if (mismatches == 0 && owed_words.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/kwslm_pkg.sv
hw/rtl/kwslm_dp.sv
hw/rtl/kwslm_ctl.sv
hw/rtl/kw_serial_link_master.sv
tb/tb_kw_serial_link_master.sv
